[design/newton_square_root_unit_defines.svh]
// ----------------------------------------------------------------------------
// newton square root unit assertion macros
// shared concurrent check forms, clocked on clk and quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef NEWTON_SQUARE_ROOT_UNIT_DEFINES_SVH
`define NEWTON_SQUARE_ROOT_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define NSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsr same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define NSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsr next-cycle check failed");

`endif

[design/nsr_pkg.sv]
// ----------------------------------------------------------------------------
// nsr_pkg
// widths, register codes and control structs for the newton square root unit
// ----------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // dividend is the radicand shifted up by the fraction bits
  localparam int DIVIDEND_W = DATA_WIDTH + FRAC_BITS;
  // running estimate, one guard bit above the radicand
  localparam int EST_W      = DATA_WIDTH + 1;
  localparam int SEED_W     = DIVIDEND_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

  localparam int ROOT_W     = 25;
  localparam int TOL_W      = 16;
  localparam int ITER_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = CFG_IDX_W'(1);

  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(7);
  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(64);

  // 256.0 in q16.16
  localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(1) << (ROOT_W - 1);

  typedef struct packed {
    logic start;
  } nsr_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } nsr_div_sts_t;

endpackage

`default_nettype wire

[design/nsr_serial_div.sv]
// ----------------------------------------------------------------------------
// nsr_serial_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module nsr_serial_div
  import nsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire nsr_div_ctl_t          ctl,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [EST_W-1:0]      divisor,
  output nsr_div_sts_t               sts,
  output logic [DIVIDEND_W-1:0]      quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [EST_W-1:0]      rem_r;
  logic [EST_W-1:0]      dvs_r;
  logic [DIVIDEND_W-1:0] quo_r;

  logic [EST_W:0] trial;
  logic [EST_W:0] trial_sub;
  logic           fits;

  // bring down the next dividend bit and try the subtract
  assign trial     = {rem_r, quo_r[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dvs_r};
  assign fits      = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= (divisor == '0) ? EST_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[EST_W-1:0] : trial[EST_W-1:0];
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

[design/newton_square_root_unit.sv]
// ----------------------------------------------------------------------------
// newton_square_root_unit
// q16.16 square root by newton iteration with tolerance and iteration cap
// ----------------------------------------------------------------------------
// One beat in, one beat out. The root starts from 1.0; the first step is
// taken without a divide (x/1.0 is x itself) and without a convergence test.
// Each later step divides (x << 16) by the estimate in a bit-serial restoring
// divider, one quotient bit per cycle; a step is a launch, the divide, and
// then the sum and the check. The number of tested steps runs from 1 to
// max_iterations, and a cap of zero counts as one; a zero radicand skips
// the steps. The divider sets the rate. A new beat
// is taken only once the previous one has been written to the output
// register, which holds its result until the sink takes it.
// The result saturates at 256.0 and limit_hit flags that the cap stopped the
// loop before the change fell within tolerance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "newton_square_root_unit_defines.svh"

module newton_square_root_unit
  import nsr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration writes
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // radicand beats
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [DATA_WIDTH-1:0] in_radicand,
  // root beats
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ROOT_W-1:0]          out_root,
  output logic                       out_limit_hit
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_CHECK,
    ST_FINISH
  } state_t;

  state_t              state_r;
  logic [DATA_WIDTH-1:0] x_r;
  logic [EST_W-1:0]    est_r;
  logic [EST_W-1:0]    new_r;
  logic [ITER_W-1:0]   iter_cnt_r;
  logic                conv_r;
  logic [TOL_W-1:0]    tol_r;
  logic [ITER_W-1:0]   max_iter_r;
  logic                out_valid_r;
  logic [ROOT_W-1:0]   out_root_r;
  logic                out_limit_hit_r;

  nsr_div_ctl_t          div_ctl;
  nsr_div_sts_t          div_sts;
  logic [DIVIDEND_W-1:0] quotient;

  logic                  in_beat;
  logic                  out_free;
  logic [ITER_W-1:0]     cap;
  logic [ITER_W-1:0]     iter_cnt_nxt;
  logic [SEED_W-1:0]     seed_sum;
  logic [EST_W-1:0]      seed;
  logic [DIVIDEND_W:0]   step_sum;
  logic [EST_W-1:0]      new_nxt;
  logic [EST_W-1:0]      delta;
  logic                  close;
  logic [ROOT_W-1:0]     root_sat;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r      <= TOL_RESET;
      max_iter_r <= ITER_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TOLERANCE: tol_r      <= cfg_wdata[TOL_W-1:0];
        CFG_MAX_ITER:  max_iter_r <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // a cap of zero behaves as one
  assign cap = (max_iter_r == '0) ? ITER_W'(1) : max_iter_r;

  // ------------------------------------------------------------- datapath
  // first step from 1.0: (x + 1.0) / 2, no divide needed
  assign seed_sum = SEED_W'(in_radicand) + (SEED_W'(1) << FRAC_BITS);
  assign seed     = EST_W'(seed_sum >> 1);

  // newton update (q + r) / 2, truncating
  assign step_sum = {1'b0, quotient} + (DIVIDEND_W + 1)'(est_r);
  assign new_nxt  = EST_W'(step_sum >> 1);

  // change between estimates against the tolerance
  assign delta = (new_r >= est_r) ? (new_r - est_r) : (est_r - new_r);
  assign close = delta <= EST_W'(tol_r);

  assign iter_cnt_nxt = iter_cnt_r + ITER_W'(1);

  // clamp to 256.0
  assign root_sat = (est_r > EST_W'(ROOT_MAX)) ? ROOT_MAX : est_r[ROOT_W-1:0];

  // one divide per tested step
  assign div_ctl.start = (state_r == ST_START);

  nsr_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend ({x_r, FRAC_BITS'(0)}),
    .divisor  (est_r),
    .sts      (div_sts),
    .quotient (quotient)
  );

  // ------------------------------------------------------------ handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_beat  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // ------------------------------------------------------------ sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // finish reloads the output register itself
      if (out_valid_r && !out_stall && (state_r != ST_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            x_r        <= in_radicand;
            iter_cnt_r <= '0;
            if (in_radicand == '0) begin
              // zero radicand: root zero, counts as converged
              est_r   <= '0;
              conv_r  <= 1'b1;
              state_r <= ST_FINISH;
            end else begin
              est_r   <= seed;
              conv_r  <= 1'b0;
              state_r <= ST_START;
            end
          end
        end
        ST_START: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (div_sts.done) begin
            new_r   <= new_nxt;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          est_r      <= new_r;
          iter_cnt_r <= iter_cnt_nxt;
          conv_r     <= close;
          if (close || (iter_cnt_nxt == cap)) begin
            state_r <= ST_FINISH;
          end else begin
            state_r <= ST_START;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_root_r      <= root_sat;
            out_limit_hit_r <= !conv_r;
            state_r         <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_root      = out_root_r;
  assign out_limit_hit = out_limit_hit_r;

  // ----------------------------------------------------------- assertions
  `NSR_ASSERT_NEXT(a_beat_leaves_idle, in_beat, state_r != ST_IDLE)
  `NSR_ASSERT_NOW(a_div_done_in_div, div_sts.done, state_r == ST_DIV)
  `NSR_ASSERT_NOW(a_div_busy_in_div, div_sts.busy, state_r == ST_DIV)
  `NSR_ASSERT_NOW(a_iter_below_cap, state_r == ST_DIV, iter_cnt_r < cap)
  `NSR_ASSERT_NOW(a_limit_root_nonzero, out_valid_r && out_limit_hit_r, out_root_r != '0)

endmodule

`default_nettype wire
